FILE: src/ptle_pkg.sv
// shared constants and types for the process table lifecycle engine
package ptle_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_PID_BITS    = 16;
   localparam int STATUS_BITS     = 16;

   typedef enum logic [1:0] {
      REQ_FORK = 2'd0,
      REQ_EXIT = 2'd1,
      REQ_WAIT = 2'd2,
      REQ_KILL = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      LIFE_RUN    = 2'd0,
      LIFE_WAIT   = 2'd1,
      LIFE_ZOMBIE = 2'd2
   } life_type;

   typedef enum logic [2:0] {
      OUT_OK        = 3'd0,
      OUT_FULL      = 3'd1,
      OUT_NO_PARENT = 3'd2,
      OUT_NOT_FOUND = 3'd3,
      OUT_EXITED    = 3'd4,
      OUT_NO_CHILD  = 3'd5,
      OUT_BLOCK     = 3'd6,
      OUT_PIDS_GONE = 3'd7
   } outcome_type;

endpackage

FILE: src/process_table_lifecycle_engine_unit.sv
// Process table lifecycle engine, top level. The table lives in a ring of
// TABLE_DEPTH entry cells that rotates one place per cycle while a request
// is scanned or applied; a request takes one full rotation to scan (lookups,
// child match) and, when the table changes, a second rotation to rewrite it,
// during which a reaped entry is closed up by taking each later entry from
// the second cell. One request is in flight at a time.
module process_table_lifecycle_engine_unit
   import ptle_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int PID_BITS    = DEF_PID_BITS,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [PID_BITS-1:0]           req_target_pid,
   input  logic signed [PID_BITS:0]      req_wanted_child,
   input  logic signed [STATUS_BITS-1:0] req_exit_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_outcome,
   output logic [PID_BITS-1:0]           rsp_pid_out,
   output logic signed [STATUS_BITS-1:0] rsp_reaped_status,
   output logic [CW-1:0]                 rsp_live_entries
);

   logic                          shift_en;
   logic [PID_BITS-1:0]           c_pid    [TABLE_DEPTH+1];
   logic [PID_BITS-1:0]           c_parent [TABLE_DEPTH+1];
   life_type                      c_life   [TABLE_DEPTH+1];
   logic signed [STATUS_BITS-1:0] c_exit   [TABLE_DEPTH+1];

   ptle_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PID_BITS    (PID_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_target_pid    (req_target_pid),
      .req_wanted_child  (req_wanted_child),
      .req_exit_code     (req_exit_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_outcome       (rsp_outcome),
      .rsp_pid_out       (rsp_pid_out),
      .rsp_reaped_status (rsp_reaped_status),
      .rsp_live_entries  (rsp_live_entries),
      .shift_en          (shift_en),
      .head_pid          (c_pid[0]),
      .head_parent       (c_parent[0]),
      .head_life         (c_life[0]),
      .head_exit         (c_exit[0]),
      .second_pid        (c_pid[1]),
      .next_parent       (c_parent[1]),
      .next_life         (c_life[1]),
      .next_exit         (c_exit[1]),
      .tail_pid          (c_pid[TABLE_DEPTH]),
      .tail_parent       (c_parent[TABLE_DEPTH]),
      .tail_life         (c_life[TABLE_DEPTH]),
      .tail_exit         (c_exit[TABLE_DEPTH])
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ptle_cell #(
         .PID_BITS  (PID_BITS),
         .INIT_HOLD (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .pid_in     (c_pid[i+1]),
         .parent_in  (c_parent[i+1]),
         .life_in    (c_life[i+1]),
         .exit_in    (c_exit[i+1]),
         .pid_out    (c_pid[i]),
         .parent_out (c_parent[i]),
         .life_out   (c_life[i]),
         .exit_out   (c_exit[i])
      );
   end

endmodule

FILE: src/ptle_cell.sv
// one table entry in the rotating chain
module ptle_cell
   import ptle_pkg::*;
#(
   parameter int PID_BITS  = DEF_PID_BITS,
   parameter bit INIT_HOLD = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [PID_BITS-1:0]           pid_in,
   input  logic [PID_BITS-1:0]           parent_in,
   input  life_type                      life_in,
   input  logic signed [STATUS_BITS-1:0] exit_in,
   output logic [PID_BITS-1:0]           pid_out,
   output logic [PID_BITS-1:0]           parent_out,
   output life_type                      life_out,
   output logic signed [STATUS_BITS-1:0] exit_out
);

   logic [PID_BITS-1:0]           pid_ff;
   logic [PID_BITS-1:0]           parent_ff;
   life_type                      life_ff;
   logic signed [STATUS_BITS-1:0] exit_ff;

   always_ff @(posedge clock) begin
      if (INIT_HOLD && reset) begin
         pid_ff    <= PID_BITS'(1);
         parent_ff <= '0;
         life_ff   <= LIFE_RUN;
         exit_ff   <= '1;
      end else if (shift_en) begin
         pid_ff    <= pid_in;
         parent_ff <= parent_in;
         life_ff   <= life_in;
         exit_ff   <= exit_in;
      end
   end

   assign pid_out    = pid_ff;
   assign parent_out = parent_ff;
   assign life_out   = life_ff;
   assign exit_out   = exit_ff;

endmodule

FILE: src/ptle_ctrl.sv
// request sequencer: scan pass over the chain, then an update pass when the table changes
module ptle_ctrl
   import ptle_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int PID_BITS    = DEF_PID_BITS,
   localparam int IW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [PID_BITS-1:0]           req_target_pid,
   input  logic signed [PID_BITS:0]      req_wanted_child,
   input  logic signed [STATUS_BITS-1:0] req_exit_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_outcome,
   output logic [PID_BITS-1:0]           rsp_pid_out,
   output logic signed [STATUS_BITS-1:0] rsp_reaped_status,
   output logic [CW-1:0]                 rsp_live_entries,
   output logic                          shift_en,
   input  logic [PID_BITS-1:0]           head_pid,
   input  logic [PID_BITS-1:0]           head_parent,
   input  life_type                      head_life,
   input  logic signed [STATUS_BITS-1:0] head_exit,
   input  logic [PID_BITS-1:0]           second_pid,
   input  logic [PID_BITS-1:0]           next_parent,
   input  life_type                      next_life,
   input  logic signed [STATUS_BITS-1:0] next_exit,
   output logic [PID_BITS-1:0]           tail_pid,
   output logic [PID_BITS-1:0]           tail_parent,
   output life_type                      tail_life,
   output logic signed [STATUS_BITS-1:0] tail_exit
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_APPLY, ST_RESP
   } state_type;

   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   state_type                     state_ff;
   logic [IW-1:0]                 idx_ff;
   logic [CW-1:0]                 count_ff;
   logic [PID_BITS:0]             next_id_ff;
   req_kind_type                  kind_ff;
   logic [PID_BITS-1:0]           target_ff;
   logic signed [PID_BITS:0]      wanted_ff;
   logic signed [STATUS_BITS-1:0] code_ff;
   logic                          pfound_ff;
   logic [IW-1:0]                 pidx_ff;
   life_type                      plife_ff;
   logic                          matched_ff;
   logic                          found_ff;
   logic [IW-1:0]                 fidx_ff;
   logic [PID_BITS-1:0]           fpid_ff;
   logic signed [STATUS_BITS-1:0] fstat_ff;
   logic                          app_ff;
   logic                          mod_ff;
   logic                          del_ff;
   logic [IW-1:0]                 aidx_ff;
   life_type                      mlife_ff;
   logic                          mexit_ff;
   logic [2:0]                    outcome_ff;
   logic [PID_BITS-1:0]           pid_out_ff;
   logic signed [STATUS_BITS-1:0] status_ff;

   state_type                     state_in;
   logic [CW-1:0]                 count_in;
   logic [PID_BITS:0]             next_id_in;
   logic                          app_in;
   logic                          mod_in;
   logic                          del_in;
   logic [IW-1:0]                 aidx_in;
   life_type                      mlife_in;
   logic                          mexit_in;
   logic [2:0]                    outcome_in;
   logic [PID_BITS-1:0]           pid_out_in;
   logic signed [STATUS_BITS-1:0] status_in;

   logic in_range;
   logic want_ok;
   logic use_next;

   assign in_range = CW'(idx_ff) < count_ff;
   assign want_ok  = (wanted_ff == '1) ||
                     (!wanted_ff[PID_BITS] && (wanted_ff[PID_BITS-1:0] == head_pid));
   assign use_next = (state_ff == ST_APPLY) && del_ff && (idx_ff >= fidx_ff);

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_outcome       = outcome_ff;
   assign rsp_pid_out       = pid_out_ff;
   assign rsp_reaped_status = status_ff;
   assign rsp_live_entries  = count_ff;
   assign shift_en          = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);

   always_comb begin
      tail_pid    = use_next ? second_pid  : head_pid;
      tail_parent = use_next ? next_parent : head_parent;
      tail_life   = use_next ? next_life   : head_life;
      tail_exit   = use_next ? next_exit   : head_exit;
      if ((state_ff == ST_APPLY) && (idx_ff == aidx_ff)) begin
         if (app_ff) begin
            tail_pid    = pid_out_ff;
            tail_parent = target_ff;
            tail_life   = LIFE_RUN;
            tail_exit   = '1;
         end
         if (mod_ff) begin
            tail_life = mlife_ff;
            if (mexit_ff) begin
               tail_exit = code_ff;
            end
         end
      end
   end

   // decision taken after the scan pass
   always_comb begin
      state_in   = ST_RESP;
      count_in   = count_ff;
      next_id_in = next_id_ff;
      app_in     = 1'b0;
      mod_in     = 1'b0;
      del_in     = 1'b0;
      mexit_in   = 1'b0;
      mlife_in   = LIFE_ZOMBIE;
      aidx_in    = pidx_ff;
      outcome_in = OUT_OK;
      pid_out_in = '0;
      status_in  = '0;
      case (kind_ff)
         REQ_FORK: begin
            if (count_ff >= CW'(TABLE_DEPTH)) begin
               outcome_in = OUT_FULL;
            end else if (!pfound_ff) begin
               outcome_in = OUT_NO_PARENT;
            end else if (next_id_ff[PID_BITS]) begin
               outcome_in = OUT_PIDS_GONE;
            end else begin
               outcome_in = OUT_OK;
               pid_out_in = next_id_ff[PID_BITS-1:0];
               next_id_in = next_id_ff + 1'b1;
               app_in     = 1'b1;
               aidx_in    = count_ff[IW-1:0];
               count_in   = count_ff + 1'b1;
               state_in   = ST_APPLY;
            end
         end
         REQ_WAIT: begin
            if (!pfound_ff) begin
               outcome_in = OUT_NO_PARENT;
            end else if (!matched_ff) begin
               outcome_in = OUT_NO_CHILD;
            end else if (!found_ff) begin
               outcome_in = OUT_BLOCK;
               if (plife_ff == LIFE_RUN) begin
                  mod_in   = 1'b1;
                  mlife_in = LIFE_WAIT;
                  state_in = ST_APPLY;
               end
            end else begin
               outcome_in = OUT_OK;
               pid_out_in = fpid_ff;
               status_in  = fstat_ff;
               mod_in     = 1'b1;
               mlife_in   = (plife_ff == LIFE_WAIT) ? LIFE_RUN : plife_ff;
               del_in     = 1'b1;
               count_in   = count_ff - 1'b1;
               state_in   = ST_APPLY;
            end
         end
         default: begin
            if (!pfound_ff) begin
               outcome_in = OUT_NOT_FOUND;
            end else if (plife_ff == LIFE_ZOMBIE) begin
               outcome_in = OUT_EXITED;
            end else begin
               outcome_in = OUT_OK;
               mod_in     = 1'b1;
               mexit_in   = 1'b1;
               state_in   = ST_APPLY;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= CW'(1);
         next_id_ff <= (PID_BITS+1)'(2);
         idx_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff    <= req_kind_type'(req_type);
                  target_ff  <= req_target_pid;
                  wanted_ff  <= req_wanted_child;
                  code_ff    <= (req_type == REQ_KILL) ? '1 : req_exit_code;
                  idx_ff     <= '0;
                  pfound_ff  <= 1'b0;
                  matched_ff <= 1'b0;
                  found_ff   <= 1'b0;
                  state_ff   <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (in_range) begin
                  if (!pfound_ff && (head_pid == target_ff)) begin
                     pfound_ff <= 1'b1;
                     pidx_ff   <= idx_ff;
                     plife_ff  <= head_life;
                  end
                  if ((kind_ff == REQ_WAIT) && (head_parent == target_ff) && want_ok &&
                      !found_ff) begin
                     matched_ff <= 1'b1;
                     if (head_life == LIFE_ZOMBIE) begin
                        found_ff <= 1'b1;
                        fidx_ff  <= idx_ff;
                        fpid_ff  <= head_pid;
                        fstat_ff <= head_exit;
                     end
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DECIDE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_DECIDE: begin
               app_ff     <= app_in;
               mod_ff     <= mod_in;
               del_ff     <= del_in;
               mexit_ff   <= mexit_in;
               mlife_ff   <= mlife_in;
               aidx_ff    <= aidx_in;
               outcome_ff <= outcome_in;
               pid_out_ff <= pid_out_in;
               status_ff  <= status_in;
               count_ff   <= count_in;
               next_id_ff <= next_id_in;
               state_ff   <= state_in;
            end
            ST_APPLY: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= ST_RESP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/ptle_checker.sv
// port checker for the process table lifecycle engine
module ptle_checker
   import ptle_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int PID_BITS    = DEF_PID_BITS,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_outcome,
   input logic [PID_BITS-1:0]           rsp_pid_out,
   input logic signed [STATUS_BITS-1:0] rsp_reaped_status,
   input logic [CW-1:0]                 rsp_live_entries
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) &&
      $stable(rsp_pid_out) && $stable(rsp_live_entries))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("request taken while another in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_entries <= CW'(TABLE_DEPTH))
      else $error("entry count out of range");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != OUT_OK) |-> (rsp_pid_out == '0) &&
      (rsp_reaped_status == '0))
      else $error("nonzero payload on failed request");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("ready for a request while response pending");

endmodule

bind process_table_lifecycle_engine_unit ptle_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .PID_BITS    (PID_BITS)
) u_ptle_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_outcome       (rsp_outcome),
   .rsp_pid_out       (rsp_pid_out),
   .rsp_reaped_status (rsp_reaped_status),
   .rsp_live_entries  (rsp_live_entries)
);
